@@ hw/rtl/jsu_pkg.sv @@
// Shared types and constants for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

	typedef enum logic [2:0] {
		MODE_BODY    = 3'd0,
		MODE_ESC     = 3'd1,
		MODE_HEX1    = 3'd2,
		MODE_HIGH    = 3'd3,
		MODE_HIGH_BS = 3'd4,
		MODE_HEX2    = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_CLOSED = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_TRUNC_ESC = 3'd0,
		ERR_BAD_ESC   = 3'd1,
		ERR_TRUNC_U   = 3'd2,
		ERR_BAD_HEX   = 3'd3,
		ERR_CTRL      = 3'd4,
		ERR_UNTERM    = 3'd5
	} err_t;

	localparam int MaxData = 6;

	localparam logic [15:0] HighFirst = 16'hD800;
	localparam logic [15:0] HighLast  = 16'hDBFF;
	localparam logic [15:0] LowFirst  = 16'hDC00;
	localparam logic [15:0] LowLast   = 16'hDFFF;
	localparam logic [20:0] SuppBase  = 21'h10000;
	localparam logic [20:0] Replace   = 21'h0FFFD;

	// Decoded results of one item: data bytes first, then an optional closing result.
	typedef struct packed {
		logic [MaxData-1:0][7:0] data;
		logic [2:0]              n_data;
		logic                    tail_v;
		kind_t                   tail_kind;
		err_t                    code;
	} desc_t;

endpackage

`default_nettype wire

@@ hw/rtl/jsu_in_if.sv @@
// Input channel: raw string-body bytes and end-of-input mark.
`default_nettype none

interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       input_end;

	modport source(output valid, output in_byte, output input_end, input ready);
	modport sink(input valid, input in_byte, input input_end, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/jsu_out_if.sv @@
// Output channel: decoded bytes, close and error results.
`default_nettype none

interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic [2:0] error_code;
	logic       last;

	modport source(output valid, output out_kind, output out_byte, output error_code,
		output last, input ready);
	modport sink(input valid, input out_kind, input out_byte, input error_code,
		input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/jsu_decode.sv @@
// Escape state machine: decodes one item into its result bytes and updates state.
`default_nettype none

module jsu_decode (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    in_byte,
	input  wire logic          input_end,
	output jsu_pkg::desc_t     desc,
	output logic               has_result
);
	import jsu_pkg::*;

	mode_t       mode_q, mode_d;
	logic [1:0]  dc_q, dc_d;
	logic [15:0] acc_q, acc_d;
	logic [15:0] held_q, held_d;

	logic [4:0]  hexv;
	logic [15:0] acc_new;
	logic        do_body, do_esc, restart, pre, main_raw, main_cp;
	logic [7:0]  raw_b;
	logic [20:0] cp;
	logic        acc_high, acc_low;
	logic [3:0][7:0] m;
	logic [2:0]  mlen;

	logic                    tail_v;
	kind_t                   tail_kind;
	err_t                    err_code;
	logic [MaxData-1:0][7:0] data_o;
	logic [2:0]              n_data_o;

	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd16;
		if (c >= "0" && c <= "9") v = 5'(c - "0");
		else if (c >= "a" && c <= "f") v = 5'(c - "a" + 8'd10);
		else if (c >= "A" && c <= "F") v = 5'(c - "A" + 8'd10);
		return v;
	endfunction

	assign hexv     = hex_value(in_byte);
	assign acc_new  = {acc_q[11:0], hexv[3:0]};
	assign acc_high = (acc_new >= HighFirst) && (acc_new <= HighLast);
	assign acc_low  = (acc_new >= LowFirst) && (acc_new <= LowLast);

	always_comb begin
		mode_d    = mode_q;
		dc_d      = dc_q;
		acc_d     = acc_q;
		held_d    = held_q;
		do_body   = 1'b0;
		do_esc    = 1'b0;
		restart   = 1'b0;
		pre       = 1'b0;
		main_raw  = 1'b0;
		main_cp   = 1'b0;
		raw_b     = 8'd0;
		cp        = 21'd0;
		tail_v    = 1'b0;
		tail_kind = KIND_DATA;
		err_code  = ERR_TRUNC_ESC;

		if (input_end) begin
			restart   = 1'b1;
			tail_v    = 1'b1;
			tail_kind = KIND_ERROR;
			unique case (mode_q)
				MODE_ESC:  err_code = ERR_TRUNC_ESC;
				MODE_HEX1, MODE_HEX2: err_code = ERR_TRUNC_U;
				MODE_HIGH: begin
					pre      = 1'b1;
					err_code = ERR_UNTERM;
				end
				MODE_HIGH_BS: begin
					pre      = 1'b1;
					err_code = ERR_TRUNC_ESC;
				end
				default:   err_code = ERR_UNTERM;
			endcase
		end else begin
			unique case (mode_q)
				MODE_ESC: do_esc = 1'b1;
				MODE_HEX1, MODE_HEX2: begin
					if (hexv[4]) begin
						restart   = 1'b1;
						tail_v    = 1'b1;
						tail_kind = KIND_ERROR;
						err_code  = ERR_BAD_HEX;
					end else if (dc_q != 2'd3) begin
						acc_d = acc_new;
						dc_d  = dc_q + 2'd1;
					end else begin
						acc_d = 16'd0;
						dc_d  = 2'd0;
						if (mode_q == MODE_HEX2 && acc_low) begin
							held_d  = 16'd0;
							mode_d  = MODE_BODY;
							main_cp = 1'b1;
							cp      = SuppBase + {1'b0, held_q[9:0], acc_new[9:0]};
						end else begin
							if (mode_q == MODE_HEX2) begin
								held_d = 16'd0;
								pre    = 1'b1;
							end
							if (acc_high) begin
								held_d = acc_new;
								mode_d = MODE_HIGH;
							end else begin
								mode_d  = MODE_BODY;
								main_cp = 1'b1;
								cp      = acc_low ? Replace : {5'd0, acc_new};
							end
						end
					end
				end
				MODE_HIGH: begin
					if (in_byte == "\\") begin
						mode_d = MODE_HIGH_BS;
					end else begin
						held_d  = 16'd0;
						mode_d  = MODE_BODY;
						pre     = 1'b1;
						do_body = 1'b1;
					end
				end
				MODE_HIGH_BS: begin
					if (in_byte == "u") begin
						mode_d = MODE_HEX2;
						dc_d   = 2'd0;
						acc_d  = 16'd0;
					end else begin
						held_d = 16'd0;
						pre    = 1'b1;
						do_esc = 1'b1;
					end
				end
				default: do_body = 1'b1;
			endcase
		end

		if (do_body) begin
			mode_d = MODE_BODY;
			if (in_byte == "\"") begin
				restart   = 1'b1;
				tail_v    = 1'b1;
				tail_kind = KIND_CLOSED;
			end else if (in_byte == "\\") begin
				mode_d = MODE_ESC;
			end else if (in_byte < 8'h20) begin
				restart   = 1'b1;
				tail_v    = 1'b1;
				tail_kind = KIND_ERROR;
				err_code  = ERR_CTRL;
			end else begin
				main_raw = 1'b1;
				raw_b    = in_byte;
			end
		end

		if (do_esc) begin
			mode_d   = MODE_BODY;
			main_raw = 1'b1;
			case (in_byte)
				"\"": raw_b = 8'h22;
				"\\": raw_b = 8'h5C;
				"/":  raw_b = 8'h2F;
				"b":  raw_b = 8'h08;
				"f":  raw_b = 8'h0C;
				"n":  raw_b = 8'h0A;
				"r":  raw_b = 8'h0D;
				"t":  raw_b = 8'h09;
				"u": begin
					main_raw = 1'b0;
					mode_d   = MODE_HEX1;
					dc_d     = 2'd0;
					acc_d    = 16'd0;
				end
				default: begin
					main_raw  = 1'b0;
					restart   = 1'b1;
					tail_v    = 1'b1;
					tail_kind = KIND_ERROR;
					err_code  = ERR_BAD_ESC;
				end
			endcase
		end

		if (restart) begin
			mode_d = MODE_BODY;
			dc_d   = 2'd0;
			acc_d  = 16'd0;
			held_d = 16'd0;
		end
	end

	// UTF-8 encoding of the main result
	always_comb begin
		m    = '0;
		mlen = 3'd0;
		if (main_raw) begin
			m[0] = raw_b;
			mlen = 3'd1;
		end else if (main_cp) begin
			if (cp < 21'h80) begin
				m[0] = cp[7:0];
				mlen = 3'd1;
			end else if (cp < 21'h800) begin
				m[0] = {3'b110, cp[10:6]};
				m[1] = {2'b10, cp[5:0]};
				mlen = 3'd2;
			end else if (cp < 21'h10000) begin
				m[0] = {4'b1110, cp[15:12]};
				m[1] = {2'b10, cp[11:6]};
				m[2] = {2'b10, cp[5:0]};
				mlen = 3'd3;
			end else begin
				m[0] = {5'b11110, cp[20:18]};
				m[1] = {2'b10, cp[17:12]};
				m[2] = {2'b10, cp[11:6]};
				m[3] = {2'b10, cp[5:0]};
				mlen = 3'd4;
			end
		end
	end

	// Replacement character (EF BF BD) goes ahead of the main bytes
	always_comb begin
		data_o = '0;
		if (pre) begin
			data_o[0] = 8'hEF;
			data_o[1] = 8'hBF;
			data_o[2] = 8'hBD;
			data_o[3] = m[0];
			data_o[4] = m[1];
			data_o[5] = m[2];
			n_data_o  = mlen + 3'd3;
		end else begin
			data_o[0] = m[0];
			data_o[1] = m[1];
			data_o[2] = m[2];
			data_o[3] = m[3];
			n_data_o  = mlen;
		end
	end

	assign desc = '{data: data_o, n_data: n_data_o, tail_v: tail_v, tail_kind: tail_kind,
		code: err_code};

	assign has_result = (n_data_o != 3'd0) || tail_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BODY;
			dc_q   <= 2'd0;
			acc_q  <= 16'd0;
			held_q <= 16'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			dc_q   <= dc_d;
			acc_q  <= acc_d;
			held_q <= held_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/json_string_unescape_utf8_core.sv @@
// JSON string body unescaper: one raw byte per item in, UTF-8 bytes and close/error results out.
// Each accepted item is decoded combinationally into a result buffer, which then drains one
// result per cycle into the output register while the output is not stalled. Items with at most
// one result stream at one per cycle likewise; an item with more results (up to 6: a replacement
// character plus a 3-byte code point, or a 4-byte code point) holds the input while the buffer
// drains. The first result of an item goes through the buffer and then the output register. Items
// that only advance state (backslash, hex digits, a held high surrogate) give no result.
`default_nettype none

module json_string_unescape_utf8_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	jsu_in_if.sink     in_ch,
	jsu_out_if.source  out_ch
);
	import jsu_pkg::*;

	desc_t      desc_new;
	logic       has_result;
	logic       in_acc;

	desc_t      desc_s1;
	logic       desc_v_s1;
	logic [2:0] idx_q;
	logic [2:0] total;
	logic       desc_last;
	logic       out_load;

	logic       out_v_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic [2:0] code_q;
	logic       last_q;

	logic [1:0] nxt_kind;
	logic [7:0] nxt_byte;
	logic [2:0] nxt_code;

	jsu_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_acc),
		.in_byte    (in_ch.in_byte),
		.input_end  (in_ch.input_end),
		.desc       (desc_new),
		.has_result (has_result)
	);

	assign total     = desc_s1.n_data + {2'd0, desc_s1.tail_v};
	assign desc_last = (idx_q == total - 3'd1);
	assign out_load  = desc_v_s1 && (!out_v_q || out_ch.ready);

	assign in_ch.ready = !desc_v_s1 || (out_load && desc_last);
	assign in_acc      = in_ch.valid && in_ch.ready;

	always_comb begin
		nxt_kind = KIND_DATA;
		nxt_byte = 8'd0;
		nxt_code = 3'd0;
		if (idx_q < desc_s1.n_data) begin
			case (idx_q)
				3'd0:    nxt_byte = desc_s1.data[0];
				3'd1:    nxt_byte = desc_s1.data[1];
				3'd2:    nxt_byte = desc_s1.data[2];
				3'd3:    nxt_byte = desc_s1.data[3];
				3'd4:    nxt_byte = desc_s1.data[4];
				3'd5:    nxt_byte = desc_s1.data[5];
				default: nxt_byte = 8'd0;
			endcase
		end else begin
			nxt_kind = desc_s1.tail_kind;
			if (desc_s1.tail_kind == KIND_ERROR) nxt_code = desc_s1.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_v_s1 <= 1'b0;
			idx_q     <= 3'd0;
		end else if (in_acc) begin
			desc_v_s1 <= has_result;
			idx_q     <= 3'd0;
		end else if (out_load) begin
			if (desc_last) begin
				desc_v_s1 <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			desc_s1 <= desc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q <= nxt_kind;
			byte_q <= nxt_byte;
			code_q <= nxt_code;
			last_q <= desc_last;
		end
	end

	assign out_ch.valid      = out_v_q;
	assign out_ch.out_kind   = kind_q;
	assign out_ch.out_byte   = byte_q;
	assign out_ch.error_code = code_q;
	assign out_ch.last       = last_q;

endmodule

`default_nettype wire

@@ dv/json_string_unescape_utf8_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the JSON string unescaper: directed and random byte streams checked by a scoreboard.
module json_string_unescape_utf8_core_tb;
	import jsu_pkg::*;

	localparam int QuietLimit = 2000;
	localparam int StimItems  = 150;
	localparam int CalmItems  = 40;

	localparam logic [7:0] QUOTE  = 8'h22;
	localparam logic [7:0] BSLASH = 8'h5C;
	localparam err_t       NoErr  = ERR_TRUNC_ESC;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		err_t       code;
		logic       last;
	} result_t;

	class unescape_scoreboard;
		mode_t       mode;
		logic [1:0]  ndig;
		logic [15:0] acc;
		logic [15:0] held;
		result_t     step_q[$];
		result_t     want_q[$];
		int          mismatches;

		function new();
			restart();
			mismatches = 0;
		endfunction

		function void restart();
			mode = MODE_BODY;
			ndig = 2'd0;
			acc  = 16'h0;
			held = 16'h0;
		endfunction

		function void emit(kind_t k, logic [7:0] b, err_t e);
			step_q.push_back('{kind: k, data: b, code: e, last: 1'b0});
		endfunction

		function void abort(err_t e);
			emit(KIND_ERROR, 8'h00, e);
			restart();
		endfunction

		function void put_utf8(logic [20:0] cp);
			if (cp < 21'h80) begin
				emit(KIND_DATA, cp[7:0], NoErr);
			end else if (cp < 21'h800) begin
				emit(KIND_DATA, {3'b110, cp[10:6]}, NoErr);
				emit(KIND_DATA, {2'b10, cp[5:0]}, NoErr);
			end else if (cp < 21'h10000) begin
				emit(KIND_DATA, {4'b1110, cp[15:12]}, NoErr);
				emit(KIND_DATA, {2'b10, cp[11:6]}, NoErr);
				emit(KIND_DATA, {2'b10, cp[5:0]}, NoErr);
			end else begin
				emit(KIND_DATA, {5'b11110, cp[20:18]}, NoErr);
				emit(KIND_DATA, {2'b10, cp[17:12]}, NoErr);
				emit(KIND_DATA, {2'b10, cp[11:6]}, NoErr);
				emit(KIND_DATA, {2'b10, cp[5:0]}, NoErr);
			end
		endfunction

		function logic [4:0] nibble_of(logic [7:0] c);
			if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
			if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
			if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
			return 5'h10;
		endfunction

		function void body_char(logic [7:0] c);
			if (c == QUOTE) begin
				emit(KIND_CLOSED, 8'h00, NoErr);
				restart();
			end else if (c == BSLASH) begin
				mode = MODE_ESC;
			end else if (c < 8'h20) begin
				abort(ERR_CTRL);
			end else begin
				emit(KIND_DATA, c, NoErr);
			end
		endfunction

		function void escape_char(logic [7:0] c);
			logic [7:0] b;
			mode = MODE_BODY;
			case (c)
				QUOTE:  b = QUOTE;
				BSLASH: b = BSLASH;
				"/":    b = "/";
				"b":    b = 8'h08;
				"f":    b = 8'h0C;
				"n":    b = 8'h0A;
				"r":    b = 8'h0D;
				"t":    b = 8'h09;
				"u": begin
					mode = MODE_HEX1;
					ndig = 2'd0;
					acc  = 16'h0;
					return;
				end
				default: begin
					abort(ERR_BAD_ESC);
					return;
				end
			endcase
			emit(KIND_DATA, b, NoErr);
		endfunction

		function void unit_ready(logic [15:0] cp);
			if (cp >= HighFirst && cp <= HighLast) begin
				held = cp;
				mode = MODE_HIGH;
			end else begin
				mode = MODE_BODY;
				put_utf8((cp >= LowFirst && cp <= LowLast) ? Replace : {5'b0, cp});
			end
		endfunction

		function void pair_ready(logic [15:0] lo);
			logic [20:0] hi_part;
			logic [20:0] lo_part;
			hi_part = {5'b0, held} - {5'b0, HighFirst};
			lo_part = {5'b0, lo} - {5'b0, LowFirst};
			held = 16'h0;
			if (lo >= LowFirst && lo <= LowLast) begin
				mode = MODE_BODY;
				put_utf8(SuppBase + (hi_part << 10) + lo_part);
			end else begin
				put_utf8(Replace);
				unit_ready(lo);
			end
		endfunction

		function void hex_char_in(logic [7:0] c);
			logic [4:0] d;
			d = nibble_of(c);
			if (d[4]) begin
				abort(ERR_BAD_HEX);
				return;
			end
			acc = {acc[11:0], d[3:0]};
			if (ndig < 2'd3) begin
				ndig++;
				return;
			end
			ndig = 2'd0;
			if (mode == MODE_HEX2) pair_ready(acc);
			else unit_ready(acc);
			acc = 16'h0;
		endfunction

		// Accepted input item: work out its results and queue them.
		function void take_item(logic [7:0] c, logic eoi);
			step_q.delete();
			if (eoi) begin
				case (mode)
					MODE_ESC: abort(ERR_TRUNC_ESC);
					MODE_HEX1, MODE_HEX2: abort(ERR_TRUNC_U);
					MODE_HIGH: begin
						put_utf8(Replace);
						abort(ERR_UNTERM);
					end
					MODE_HIGH_BS: begin
						put_utf8(Replace);
						abort(ERR_TRUNC_ESC);
					end
					default: abort(ERR_UNTERM);
				endcase
			end else begin
				case (mode)
					MODE_ESC: escape_char(c);
					MODE_HEX1, MODE_HEX2: hex_char_in(c);
					MODE_HIGH: begin
						if (c == BSLASH) begin
							mode = MODE_HIGH_BS;
						end else begin
							held = 16'h0;
							mode = MODE_BODY;
							put_utf8(Replace);
							body_char(c);
						end
					end
					MODE_HIGH_BS: begin
						if (c == "u") begin
							mode = MODE_HEX2;
							ndig = 2'd0;
							acc  = 16'h0;
						end else begin
							held = 16'h0;
							put_utf8(Replace);
							escape_char(c);
						end
					end
					default: begin
						mode = MODE_BODY;
						body_char(c);
					end
				endcase
			end
			if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
			foreach (step_q[i]) want_q.push_back(step_q[i]);
		endfunction

		function void check_result(logic [1:0] kind, logic [7:0] data, logic [2:0] code,
				logic last);
			result_t w;
			if (want_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d byte %02h code %0d last %0b",
						kind, data, code, last);
				return;
			end
			w = want_q.pop_front();
			if (kind !== w.kind || data !== w.data || code !== w.code || last !== w.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: got kind %0d byte %02h code %0d last %0b, %s %0d %02h %0d %0b",
						kind, data, code, last, "want kind/byte/code/last",
						w.kind, w.data, w.code, w.last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	jsu_in_if  in_ch ();
	jsu_out_if out_ch ();

	unescape_scoreboard sb = new();

	int   items_sent = 0;
	int   quiet      = 0;
	int   stall_left = 0;
	logic gappy      = 1'b0;
	logic sink_busy  = 1'b0;
	logic calm       = 1'b0;

	json_string_unescape_utf8_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(negedge clk) begin
		if (!calm && $urandom_range(0, 99) == 0) sink_busy <= !sink_busy;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if (!calm && sink_busy && $urandom_range(0, 3) == 0) begin
			stall_left <= $urandom_range(0, 18);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) sb.take_item(in_ch.in_byte, in_ch.input_end);
			if (out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.out_kind, out_ch.out_byte, out_ch.error_code, out_ch.last);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet <= 0;
			end else if (quiet >= QuietLimit) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic push_item(input logic [7:0] b, input logic eoi);
		int gap;
		if (!calm && gappy && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.in_byte   <= b;
		in_ch.input_end <= eoi;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
		if (items_sent >= StimItems - CalmItems) calm = 1'b1;
		@(negedge clk);
	endtask

	function automatic logic [7:0] hex_digit(logic [3:0] n);
		if (n < 4'd10) return "0" + 8'(n);
		return ($urandom_range(0, 1) ? "a" : "A") + 8'(n) - 8'd10;
	endfunction

	task automatic push_unit(input logic [15:0] v);
		push_item(BSLASH, 1'b0);
		push_item("u", 1'b0);
		for (int i = 3; i >= 0; i--) push_item(hex_digit(v[i*4 +: 4]), 1'b0);
	endtask

	function automatic logic [15:0] pick_cp(int cls);
		case (cls)
			0: return 16'($urandom_range(0, 'h7F));
			1: return 16'($urandom_range('h80, 'h7FF));
			2: return $urandom_range(0, 1) ? 16'($urandom_range('h800, 'hD7FF))
				: 16'($urandom_range('hE000, 'hFFFF));
			3: return 16'($urandom_range('hD800, 'hDBFF));
			default: return 16'($urandom_range('hDC00, 'hDFFF));
		endcase
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] b;
		do b = 8'($urandom_range('h20, 'hFF)); while (b == QUOTE || b == BSLASH);
		return b;
	endfunction

	function automatic logic [7:0] simple_letter();
		case ($urandom_range(0, 7))
			0: return QUOTE;
			1: return BSLASH;
			2: return "/";
			3: return "b";
			4: return "f";
			5: return "n";
			6: return "r";
			default: return "t";
		endcase
	endfunction

	function automatic logic [7:0] non_hex();
		logic [7:0] b;
		logic [4:0] v;
		do begin
			b = 8'($urandom_range(0, 255));
			v = sb.nibble_of(b);
		end while (!v[4]);
		return b;
	endfunction

	initial begin
		int seg;
		int k;
		in_ch.valid     = 1'b0;
		in_ch.in_byte   = 8'h00;
		in_ch.input_end = 1'b0;
		out_ch.ready    = 1'b0;
		arst_n          = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, escapes, truncations, lone surrogates, bad hex
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(BSLASH, 1'b0);
		push_item("n", 1'b0);
		push_item(BSLASH, 1'b0);
		push_item("q", 1'b0);
		push_item(8'h00, 1'b1);
		push_item(BSLASH, 1'b0);
		push_item(8'hFF, 1'b1);
		push_unit(16'hD83D);
		push_item(8'h00, 1'b1);
		push_unit(16'hDC00);
		push_item(BSLASH, 1'b0);
		push_item("u", 1'b0);
		push_item("1", 1'b0);
		push_item("2", 1'b0);
		push_item("g", 1'b0);
		push_item(QUOTE, 1'b0);

		while (items_sent < StimItems) begin
			gappy = $urandom_range(0, 2) != 0;
			seg = $urandom_range(0, 19);
			case (seg)
				0, 1, 2, 3, 19: begin
					k = $urandom_range(1, 4);
					repeat (k) push_item(plain_char(), 1'b0);
				end
				4: push_item(8'($urandom_range(0, 255)), 1'b0);
				5, 6: begin
					push_item(BSLASH, 1'b0);
					push_item(simple_letter(), 1'b0);
				end
				7: begin
					push_item(BSLASH, 1'b0);
					push_item(8'($urandom_range(0, 255)), 1'b0);
				end
				8, 9, 10: begin
					k = $urandom_range(0, 9);
					push_unit(k == 9 ? 16'hFFFF : k == 8 ? 16'h0000 : pick_cp(k % 5));
				end
				11, 12: begin
					push_unit(pick_cp(3));
					push_unit(pick_cp(4));
				end
				13: begin
					push_unit(pick_cp(3));
					case ($urandom_range(0, 4))
						0: push_item(plain_char(), 1'b0);
						1: push_item(8'($urandom_range(0, 255)), 1'b0);
						2: begin
							push_item(BSLASH, 1'b0);
							push_item($urandom_range(0, 1) ? simple_letter()
								: 8'($urandom_range(0, 255)), 1'b0);
						end
						default: begin
							k = $urandom_range(0, 3);
							push_unit(pick_cp(k == 3 ? 3 : k));
						end
					endcase
				end
				14: begin
					push_item(BSLASH, 1'b0);
					push_item("u", 1'b0);
					k = $urandom_range(0, 3);
					repeat (k) push_item(hex_digit(4'($urandom_range(0, 15))), 1'b0);
					push_item(non_hex(), 1'b0);
				end
				15: begin
					push_unit(pick_cp(3));
					push_item(BSLASH, 1'b0);
					push_item("u", 1'b0);
					k = $urandom_range(0, 3);
					repeat (k) push_item(hex_digit(4'($urandom_range(0, 15))), 1'b0);
					if ($urandom_range(0, 1)) push_item(non_hex(), 1'b0);
					else push_item(8'($urandom_range(0, 255)), 1'b1);
				end
				16, 17: push_item(QUOTE, 1'b0);
				default: begin
					case ($urandom_range(0, 4))
						0: ;
						1: push_item(BSLASH, 1'b0);
						2: begin
							push_item(BSLASH, 1'b0);
							push_item("u", 1'b0);
							k = $urandom_range(0, 3);
							repeat (k) push_item(hex_digit(4'($urandom_range(0, 15))), 1'b0);
						end
						3: push_unit(pick_cp(3));
						default: begin
							push_unit(pick_cp(3));
							push_item(BSLASH, 1'b0);
						end
					endcase
					push_item(8'($urandom_range(0, 255)), 1'b1);
				end
			endcase
		end
		in_ch.valid <= 1'b0;

		while (sb.want_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.mismatches == 0 && sb.want_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_in_if.sv
hw/rtl/jsu_out_if.sv
hw/rtl/jsu_decode.sv
hw/rtl/json_string_unescape_utf8_core.sv
dv/json_string_unescape_utf8_core_tb.sv
